/* hw/rtl/mmc_pkg.sv */
// Shared types and constants for the masked pattern match counter.
package mmc_pkg;

   localparam int CFG_PATTERN_BYTES = 8;   // pattern and mask registers are 64 bits wide
   localparam int CSR_INDEX_W       = 2;
   localparam int CSR_DATA_W        = 64;
   localparam int LENGTH_W          = 4;
   localparam int ADDR_W            = 32;
   localparam int COUNT_W           = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_BYTES  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_MASK   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 2'd2;

   localparam logic [CSR_DATA_W-1:0] PATTERN_BYTES_RESET  = '0;
   localparam logic [CSR_DATA_W-1:0] PATTERN_MASK_RESET   = '1;
   localparam logic [LENGTH_W-1:0]   PATTERN_LENGTH_RESET = 4'd4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hffff_ffff;

   localparam logic KIND_MATCH   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // classified byte, front to back
   typedef struct packed {
      logic              hit;
      logic [ADDR_W-1:0] start_address;
      logic              last_byte;
   } mmc_item_type;

   typedef struct packed {
      logic               result_kind;
      logic [ADDR_W-1:0]  match_address;
      logic [COUNT_W-1:0] match_count;
      logic [ADDR_W-1:0]  first_address;
      logic               unique_match;
      logic               count_saturated;
      logic               last_result;
   } mmc_result_type;

endpackage

/* hw/rtl/mmc_fifo.sv */
// Small register-based FIFO used between front and back and on the result side.
module mmc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W:0]   rd_ptr_ff, rd_ptr_in;
   logic             do_push, do_pop;

   assign empty    = (wr_ptr_ff == rd_ptr_ff);
   assign full     = (wr_ptr_ff[PTR_W] != rd_ptr_ff[PTR_W]) &&
                     (wr_ptr_ff[PTR_W-1:0] == rd_ptr_ff[PTR_W-1:0]);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff[PTR_W-1:0]];

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff[PTR_W-1:0]] <= push_data;
      end
   end

endmodule

/* hw/rtl/mmc_front.sv */
// Front end: pattern registers, sliding byte window and masked compare.
module mmc_front import mmc_pkg::*; #(
   parameter int MAX_PATTERN_BYTES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   accept,
   input  logic [7:0]             data_byte,
   input  logic [ADDR_W-1:0]      byte_address,
   input  logic                   segment_start,
   input  logic                   last_byte,
   output mmc_item_type           item
);

   localparam logic [LENGTH_W-1:0] MAX_LEN = LENGTH_W'(MAX_PATTERN_BYTES);

   logic [CFG_PATTERN_BYTES-1:0][7:0] pattern_ff;
   logic [CFG_PATTERN_BYTES-1:0][7:0] mask_ff;
   logic [LENGTH_W-1:0]               length_ff;

   logic [MAX_PATTERN_BYTES-1:0][7:0] window_ff, window_in, window_next;
   logic [LENGTH_W-1:0]               fill_ff, fill_in, fill_next;

   logic [LENGTH_W-1:0] len_eff;
   logic                compare_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= PATTERN_BYTES_RESET;
         mask_ff    <= PATTERN_MASK_RESET;
         length_ff  <= PATTERN_LENGTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_BYTES:  pattern_ff <= csr_wdata;
            CSR_PATTERN_MASK:   mask_ff    <= csr_wdata;
            CSR_PATTERN_LENGTH: length_ff  <= csr_wdata[LENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   assign len_eff = (length_ff > MAX_LEN) ? MAX_LEN : length_ff;

   // newest byte at index 0; a segment start drops the old bytes first
   always_comb begin
      window_next[0] = data_byte;
      for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
         window_next[j] = segment_start ? 8'h00 : window_ff[j-1];
      end
      if (segment_start) begin
         fill_next = LENGTH_W'(1);
      end else if (fill_ff == MAX_LEN) begin
         fill_next = fill_ff;
      end else begin
         fill_next = fill_ff + 1'b1;
      end
   end

   // window byte j lines up with pattern byte len-1-j
   always_comb begin
      logic [LENGTH_W-1:0] pidx;
      logic [7:0]          m;
      compare_ok = 1'b1;
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         pidx = len_eff - LENGTH_W'(j) - LENGTH_W'(1);
         m    = mask_ff[pidx[2:0]];
         if (LENGTH_W'(j) < len_eff) begin
            if ((window_next[j] & m) != (pattern_ff[pidx[2:0]] & m)) begin
               compare_ok = 1'b0;
            end
         end
      end
   end

   assign item.hit           = (len_eff != '0) && (fill_next >= len_eff) && compare_ok;
   assign item.start_address = byte_address - (ADDR_W'(len_eff) - ADDR_W'(1));
   assign item.last_byte     = last_byte;

   // end of scan starts the next scan with an empty window
   always_comb begin
      window_in = window_ff;
      fill_in   = fill_ff;
      if (accept) begin
         if (last_byte) begin
            window_in = '0;
            fill_in   = '0;
         end else begin
            window_in = window_next;
            fill_in   = fill_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         fill_ff   <= '0;
      end else begin
         window_ff <= window_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

/* hw/rtl/mmc_back.sv */
// Back end: match counting, earliest address and result generation.
module mmc_back import mmc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           item_valid,
   input  mmc_item_type   item,
   output logic           item_pop,
   input  logic           result_full,
   output logic           result_push,
   output mmc_result_type result
);

   logic [COUNT_W-1:0] total_ff, total_in, total_inc;
   logic [ADDR_W-1:0]  earliest_ff, earliest_in, earliest_upd;
   logic               sat_ff, sat_in;
   logic               report_done_ff, report_done_in;
   logic               go;

   assign go           = item_valid && !result_full;
   assign total_inc    = (total_ff == COUNT_MAX) ? total_ff : total_ff + 1'b1;
   assign earliest_upd = (total_ff == '0) ? item.start_address : earliest_ff;

   always_comb begin
      total_in       = total_ff;
      earliest_in    = earliest_ff;
      sat_in         = sat_ff;
      report_done_in = report_done_ff;
      item_pop       = 1'b0;
      result_push    = 1'b0;

      result.result_kind     = KIND_MATCH;
      result.match_address   = item.start_address;
      result.match_count     = total_inc;
      result.first_address   = earliest_upd;
      result.unique_match    = (total_inc == COUNT_W'(1));
      result.count_saturated = sat_ff || (total_inc == COUNT_MAX);
      result.last_result     = 1'b0;

      if (go) begin
         if (item.hit && !report_done_ff) begin
            result_push = 1'b1;
            total_in    = total_inc;
            earliest_in = earliest_upd;
            sat_in      = sat_ff || (total_inc == COUNT_MAX);
            // a match on the last byte keeps the item, so the summary is pushed on a later pass
            if (item.last_byte) begin
               report_done_in = 1'b1;
            end else begin
               item_pop = 1'b1;
            end
         end else if (item.last_byte) begin
            result_push            = 1'b1;
            result.result_kind     = KIND_SUMMARY;
            result.match_address   = earliest_ff;
            result.match_count     = total_ff;
            result.first_address   = earliest_ff;
            result.unique_match    = (total_ff == COUNT_W'(1));
            result.count_saturated = sat_ff;
            result.last_result     = 1'b1;
            total_in       = '0;
            earliest_in    = '0;
            sat_in         = 1'b0;
            report_done_in = 1'b0;
            item_pop       = 1'b1;
         end else begin
            item_pop = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff       <= '0;
         earliest_ff    <= '0;
         sat_ff         <= 1'b0;
         report_done_ff <= 1'b0;
      end else begin
         total_ff       <= total_in;
         earliest_ff    <= earliest_in;
         sat_ff         <= sat_in;
         report_done_ff <= report_done_in;
      end
   end

endmodule

/* hw/rtl/masked_pattern_match_counter.sv */
// Masked byte pattern scanner: front compare, item queue, counter back end, result queue.
//
// Usage: configure pattern_bytes (index 0), pattern_mask (index 1) and pattern_length
// (index 2) through csr_we/csr_index/csr_wdata while the block is idle. Then push one
// byte per cycle on the req_ channel (accepted when req_push is high and req_full low),
// with req_segment_start on the first byte of each segment and req_last_byte on the
// final byte of the scan. Results come out of a queue: while rsp_empty is low the
// oldest result is on the rsp_ ports, and it is taken when rsp_pop is high.
// Each match gives one report; the last byte adds a summary with last_result set.
// Each byte is compared and classified, then written into the item queue; the back end
// counts it and queues its result for the rsp_ ports, and the summary after a match on
// the last byte is queued behind that match report. One byte per cycle is taken while
// req_full is low; a byte that matches and ends the scan stays in the item queue until
// its summary is queued. When the result side stalls, the result queue and then the
// item queue fill and req_full rises; nothing is dropped. Synchronous reset clears the
// window, count, both queues and loads register reset values (length 4, mask all ones).
module masked_pattern_match_counter import mmc_pkg::*; #(
   parameter int MAX_PATTERN_BYTES = 8,
   parameter int ITEM_QUEUE_DEPTH  = 4,
   parameter int RESULT_QUEUE_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [7:0]             req_data_byte,
   input  logic [ADDR_W-1:0]      req_byte_address,
   input  logic                   req_segment_start,
   input  logic                   req_last_byte,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic                   rsp_result_kind,
   output logic [ADDR_W-1:0]      rsp_match_address,
   output logic [COUNT_W-1:0]     rsp_match_count,
   output logic [ADDR_W-1:0]      rsp_first_address,
   output logic                   rsp_unique_match,
   output logic                   rsp_count_saturated,
   output logic                   rsp_last_result
);

   localparam int ITEM_W   = $bits(mmc_item_type);
   localparam int RESULT_W = $bits(mmc_result_type);

   logic           req_accept;
   mmc_item_type   front_item, back_item;
   logic           item_empty, item_pop;
   logic           result_full, result_push;
   mmc_result_type back_result, rsp_result;

   assign req_accept = req_push && !req_full;

   mmc_front #(
      .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (req_accept),
      .data_byte    (req_data_byte),
      .byte_address (req_byte_address),
      .segment_start(req_segment_start),
      .last_byte    (req_last_byte),
      .item         (front_item)
   );

   mmc_fifo #(
      .WIDTH(ITEM_W),
      .DEPTH(ITEM_QUEUE_DEPTH)
   ) u_item_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_data(front_item),
      .full     (req_full),
      .pop      (item_pop),
      .pop_data (back_item),
      .empty    (item_empty)
   );

   mmc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (!item_empty),
      .item       (back_item),
      .item_pop   (item_pop),
      .result_full(result_full),
      .result_push(result_push),
      .result     (back_result)
   );

   mmc_fifo #(
      .WIDTH(RESULT_W),
      .DEPTH(RESULT_QUEUE_DEPTH)
   ) u_result_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (result_push),
      .push_data(back_result),
      .full     (result_full),
      .pop      (rsp_pop),
      .pop_data (rsp_result),
      .empty    (rsp_empty)
   );

   assign rsp_result_kind     = rsp_result.result_kind;
   assign rsp_match_address   = rsp_result.match_address;
   assign rsp_match_count     = rsp_result.match_count;
   assign rsp_first_address   = rsp_result.first_address;
   assign rsp_unique_match    = rsp_result.unique_match;
   assign rsp_count_saturated = rsp_result.count_saturated;
   assign rsp_last_result     = rsp_result.last_result;

endmodule
